>>> hw/rtl/cmli_pkg.sv
// shared types and constants of the color map lookup block
package cmli_pkg;

  // transaction kinds on the input channel
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // map modes
  localparam logic [1:0] MODE_VALUES    = 2'd0;
  localparam logic [1:0] MODE_INTERVALS = 2'd1;
  localparam logic [1:0] MODE_RAMP      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE        = 2'd0;
  localparam logic [1:0] CFG_BAND_COUNT  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd2;

  // supported band counts
  localparam logic [2:0] BANDS_ONE   = 3'd1;
  localparam logic [2:0] BANDS_THREE = 3'd3;
  localparam logic [2:0] BANDS_FOUR  = 3'd4;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_BAND = 1'b1;

  localparam int QUOT_W = 8;
  localparam int NUM_W  = 40;

  // search record that walks down the row of cells
  typedef struct packed {
    logic signed [31:0] v;
    logic               exact;
    logic [31:0]        ecol;
    logic               upper;
    logic signed [31:0] lo_key;
    logic [31:0]        lo_col;
    logic signed [31:0] hi_key;
    logic [31:0]        hi_col;
    logic signed [31:0] prev_key;
    logic [31:0]        prev_col;
    logic signed [31:0] first_key;
    logic [31:0]        first_col;
    logic signed [31:0] end_key;
    logic [31:0]        end_col;
  } cmli_rec_t;

  // divider lane control
  typedef struct packed {
    logic load;
    logic step;
  } cmli_div_ctl_t;

endpackage

>>> hw/rtl/cmli_cell.sv
// one table slot: holds a key and color and updates the passing search record
module cmli_cell import cmli_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic signed [31:0] wr_key,
  input  logic [31:0]        wr_col,
  input  logic [CW-1:0]      n_i,
  input  logic               vld_i,
  input  cmli_rec_t          rec_i,
  output logic               vld_o,
  output cmli_rec_t          rec_o
);

  logic signed [31:0] key_r;
  logic [31:0]        col_r;
  logic               vld_r;
  cmli_rec_t          rec_r;
  cmli_rec_t          rec_nxt;
  logic               act;

  always_ff @(posedge clk) begin
    if (we) begin
      key_r <= wr_key;
      col_r <= wr_col;
    end
  end

  assign act = (CW'(IDX) < n_i);

  always_comb begin
    rec_nxt = rec_i;
    if (act) begin
      if (!rec_i.exact && key_r == rec_i.v) begin
        rec_nxt.exact = 1'b1;
        rec_nxt.ecol  = col_r;
      end
      if (IDX != 0 && !rec_i.upper && key_r > rec_i.v) begin
        rec_nxt.upper  = 1'b1;
        rec_nxt.lo_key = rec_i.prev_key;
        rec_nxt.lo_col = rec_i.prev_col;
        rec_nxt.hi_key = key_r;
        rec_nxt.hi_col = col_r;
      end
      rec_nxt.prev_key = key_r;
      rec_nxt.prev_col = col_r;
      if (IDX == 0) begin
        rec_nxt.first_key = key_r;
        rec_nxt.first_col = col_r;
      end
      if (CW'(IDX + 1) == n_i) begin
        rec_nxt.end_key = key_r;
        rec_nxt.end_col = col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign vld_o = vld_r;
  assign rec_o = rec_r;

endmodule

>>> hw/rtl/cmli_div.sv
// restoring divider lane, one quotient bit per step
module cmli_div import cmli_pkg::*; (
  input  logic              clk,
  input  cmli_div_ctl_t     ctl,
  input  logic [NUM_W-1:0]  num,
  input  logic [31:0]       span,
  output logic [QUOT_W-1:0] quot
);

  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  dvs_r;
  logic [QUOT_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= num;
      dvs_r <= {1'b0, span, 7'b0};
      q_r   <= '0;
    end else if (ctl.step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        q_r   <= {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUOT_W-2:0], 1'b0};
      end
      dvs_r <= {1'b0, dvs_r[NUM_W-1:1]};
    end
  end

  assign quot = q_r;

endmodule

>>> hw/rtl/color_map_lookup_interpolate.sv
// top level of the color map lookup with exact, step and ramp modes
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_ready  kind, entry_index/key/color, pixel_value/last
//  out      output     out_valid/out_ready color, status, image_last
//  cfg      input      cfg_we             cfg_index, cfg_wdata
//
// a load transaction writes its slot at the accept edge
// a pixel transaction walks the row of TABLE_ENTRIES cells, one cell a cycle,
// then one decide step, plus one multiply and eight divider steps
// when the value falls inside a ramp band
// synchronous active-low reset clears the control state and the registers
// to mode 0, three bands, one entry; the table itself holds no reset value
// a result waits in the output register while the next transaction is taken
module color_map_lookup_interpolate import cmli_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_entry_key,
  input  logic [31:0]        in_entry_color,
  input  logic signed [31:0] in_pixel_value,
  input  logic               in_pixel_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_color,
  output logic               out_status,
  output logic               out_image_last
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration registers
  logic [1:0] mode_r;
  logic [2:0] bands_r;
  logic [4:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_VALUES;
      bands_r <= BANDS_THREE;
      count_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:        mode_r  <= cfg_wdata[1:0];
        CFG_BAND_COUNT:  bands_r <= cfg_wdata[2:0];
        CFG_ENTRY_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // entry count clamped to 1 .. TABLE_ENTRIES
  logic [8:0]       cnt9;
  logic [CNT_W-1:0] n_eff;

  always_comb begin
    cnt9 = {4'b0, count_r};
    if (cnt9 == 9'd0) begin
      n_eff = CNT_W'(1);
    end else if (cnt9 > 9'(TABLE_ENTRIES)) begin
      n_eff = CNT_W'(TABLE_ENTRIES);
    end else begin
      n_eff = cnt9[CNT_W-1:0];
    end
  end

  // load slot wraps modulo the table size, by repeated subtraction
  logic [8:0] slot9;

  always_comb begin
    slot9 = {5'b0, in_entry_index};
    for (int k = 0; k < 8; k++) begin
      if (slot9 >= 9'(TABLE_ENTRIES)) begin
        slot9 = slot9 - 9'(TABLE_ENTRIES);
      end
    end
  end

  logic [2:0] state_r;
  logic       in_acc;
  logic       do_load;
  logic       do_pixel;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign do_load  = in_acc && (in_kind == KIND_LOAD);
  assign do_pixel = in_acc && (in_kind == KIND_PIXEL);

  // row of cells, record enters at cell 0
  cmli_rec_t rec_in;
  cmli_rec_t rec_chain [TABLE_ENTRIES+1];
  logic      vld_chain [TABLE_ENTRIES+1];

  always_comb begin
    rec_in   = '0;
    rec_in.v = in_pixel_value;
  end

  assign rec_chain[0] = rec_in;
  assign vld_chain[0] = do_pixel;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cmli_cell #(
      .IDX (g),
      .CW  (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .we     (do_load && (slot9[IDX_W-1:0] == IDX_W'(g))),
      .wr_key (in_entry_key),
      .wr_col (in_entry_color),
      .n_i    (n_eff),
      .vld_i  (vld_chain[g]),
      .rec_i  (rec_chain[g]),
      .vld_o  (vld_chain[g+1]),
      .rec_o  (rec_chain[g+1])
    );
  end

  cmli_rec_t tail;
  logic      tail_vld;

  assign tail     = rec_chain[TABLE_ENTRIES];
  assign tail_vld = vld_chain[TABLE_ENTRIES];

  // decide from the finished record
  logic               dec_ramp;
  logic [31:0]        dec_col;
  logic signed [32:0] span_w;
  logic signed [32:0] wlo_w;
  logic signed [32:0] whi_w;

  always_comb begin
    dec_ramp = 1'b0;
    dec_col  = tail.end_col;
    if (mode_r == MODE_VALUES) begin
      dec_col = tail.exact ? tail.ecol : 32'd0;
    end else if (tail.v < tail.first_key) begin
      dec_col = tail.first_col;
    end else if (tail.v > tail.end_key) begin
      dec_col = tail.end_col;
    end else if (tail.exact) begin
      dec_col = tail.ecol;
    end else if (tail.upper) begin
      dec_col = tail.lo_col;
      if (mode_r != MODE_INTERVALS && tail.lo_key < tail.v) begin
        dec_ramp = 1'b1;
      end
    end
  end

  assign span_w = 33'(tail.hi_key) - 33'(tail.lo_key);
  assign wlo_w  = 33'(tail.hi_key) - 33'(tail.v);
  assign whi_w  = 33'(tail.v) - 33'(tail.lo_key);

  logic        ramp_r;
  logic [31:0] res_col_r;
  logic [31:0] span_r;
  logic [31:0] wlo_r;
  logic [31:0] whi_r;
  logic [31:0] lo_col_r;
  logic [31:0] hi_col_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (do_pixel) begin
      last_r <= in_pixel_last;
    end
    if (state_r == ST_SCAN && tail_vld) begin
      res_col_r <= dec_col;
      span_r    <= span_w[31:0];
      wlo_r     <= wlo_w[31:0];
      whi_r     <= whi_w[31:0];
      lo_col_r  <= tail.lo_col;
      hi_col_r  <= tail.hi_col;
    end
  end

  // one divider lane per color band
  cmli_div_ctl_t    dctl;
  logic [NUM_W-1:0] num   [4];
  logic [7:0]       quot  [4];

  assign dctl.load = (state_r == ST_MUL);
  assign dctl.step = (state_r == ST_DIV);

  for (genvar b = 0; b < 4; b++) begin : g_band
    assign num[b] = NUM_W'(lo_col_r[8*b +: 8]) * NUM_W'(wlo_r)
                  + NUM_W'(hi_col_r[8*b +: 8]) * NUM_W'(whi_r);

    cmli_div u_div (
      .clk  (clk),
      .ctl  (dctl),
      .num  (num[b]),
      .span (span_r),
      .quot (quot[b])
    );
  end

  // final color with band mask
  logic [31:0] raw_col;
  logic [31:0] fin_col;
  logic        fin_status;

  assign raw_col = ramp_r ? {quot[3], quot[2], quot[1], quot[0]} : res_col_r;

  always_comb begin
    fin_status = STATUS_OK;
    unique case (bands_r)
      BANDS_ONE:   fin_col = {24'd0, raw_col[7:0]};
      BANDS_THREE: fin_col = {8'd0, raw_col[23:0]};
      BANDS_FOUR:  fin_col = raw_col;
      default: begin
        fin_col    = 32'd0;
        fin_status = STATUS_BAD_BAND;
      end
    endcase
  end

  logic [2:0] cnt_r;
  logic       out_valid_r;
  logic       out_load;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ramp_r  <= 1'b0;
      cnt_r   <= 3'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (do_pixel) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail_vld) begin
            ramp_r  <= dec_ramp;
            state_r <= dec_ramp ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          cnt_r   <= 3'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  logic [31:0] out_color_r;
  logic        out_status_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_color_r  <= fin_col;
      out_status_r <= fin_status;
      out_last_r   <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_color      = out_color_r;
  assign out_status     = out_status_r;
  assign out_image_last = out_last_r;

`ifndef SYNTHESIS
  // a record only leaves the row while a pixel transaction is being scanned
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld |-> state_r == ST_SCAN)
    else $error("search record left the row outside the scan state");

  // divider only runs for a ramp band
  a_div_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> ramp_r)
    else $error("divider stepping without a ramp result");

  // a new result only appears out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the finish state");
`endif

endmodule

>>> test/tb_color_map_lookup_interpolate.sv
// testbench of the color map lookup block: directed table plus random traffic
module tb_color_map_lookup_interpolate;
  import cmli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  // one pixel walks the row, decides and maybe divides
  localparam int PIXEL_CYCLES = SLOTS + 2 + 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MODE;
  logic [4:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_LOAD;
  logic [3:0] in_entry_index = '0;
  logic signed [31:0] in_entry_key = '0;
  logic [31:0] in_entry_color = '0;
  logic signed [31:0] in_pixel_value = '0;
  logic in_pixel_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_color;
  logic out_status;
  logic out_image_last;

  always #5 clk = ~clk;

  color_map_lookup_interpolate i_dut (.*);

  typedef struct packed {
    logic [31:0] color;
    logic        status;
    logic        image_last;
  } pixel_res_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         idx;
    logic signed [31:0] key;
    logic [31:0]        col;
    logic signed [31:0] value;
    logic               last;
  } xact_t;

  // shadow copy of the block's state
  logic signed [31:0] shadow_key [SLOTS];
  logic [31:0]        shadow_col [SLOTS];
  logic [1:0] cur_mode = MODE_VALUES;
  logic [2:0] cur_bands = BANDS_THREE;
  logic [4:0] cur_entries = 5'd1;

  pixel_res_t pending_colors[$];
  int mismatches = 0;
  bit failed = 1'b0;

  // exact ramp of one band set between two neighbors
  function automatic logic [31:0] ramp_mix(logic [31:0] lc, logic [31:0] hc,
      logic signed [31:0] lk, logic signed [31:0] hk, logic signed [31:0] v);
    logic [63:0] span, w_lo, w_hi, q;
    logic [31:0] r;
    span = 64'(longint'(hk) - longint'(lk));
    w_lo = 64'(longint'(hk) - longint'(v));
    w_hi = 64'(longint'(v) - longint'(lk));
    r = '0;
    for (int b = 0; b < 4; b++) begin
      q = (64'(lc[8*b +: 8]) * w_lo + 64'(hc[8*b +: 8]) * w_hi) / span;
      r[8*b +: 8] = q[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] lookup_color(logic signed [31:0] v);
    int n;
    n = (cur_entries == 0) ? 1 : (cur_entries > SLOTS ? SLOTS : cur_entries);
    if (cur_mode == MODE_VALUES) begin
      for (int i = 0; i < n; i++) if (shadow_key[i] == v) return shadow_col[i];
      return '0;
    end
    if (v < shadow_key[0]) return shadow_col[0];
    if (v > shadow_key[n-1]) return shadow_col[n-1];
    for (int i = 0; i < n; i++) if (shadow_key[i] == v) return shadow_col[i];
    for (int i = 1; i < n; i++) begin
      if (shadow_key[i] > v) begin
        if (cur_mode == MODE_INTERVALS || !(shadow_key[i-1] < v)) return shadow_col[i-1];
        return ramp_mix(shadow_col[i-1], shadow_col[i], shadow_key[i-1], shadow_key[i], v);
      end
    end
    return shadow_col[n-1];
  endfunction

  // update shadow state for one accepted transaction, queue the expected pixel
  function automatic void predict_xact(xact_t x);
    pixel_res_t r;
    if (x.kind == KIND_LOAD) begin
      shadow_key[x.idx] = x.key;
      shadow_col[x.idx] = x.col;
      return;
    end
    r.image_last = x.last;
    r.status = STATUS_OK;
    if (cur_bands == BANDS_ONE || cur_bands == BANDS_THREE || cur_bands == BANDS_FOUR) begin
      r.color = lookup_color(x.value);
      if (cur_bands == BANDS_ONE) r.color &= 32'h0000_00ff;
      else if (cur_bands == BANDS_THREE) r.color &= 32'h00ff_ffff;
    end else begin
      r.color = '0;
      r.status = STATUS_BAD_BAND;
    end
    pending_colors.push_back(r);
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    pixel_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result color=%h", out_color);
      end else begin
        want = pending_colors.pop_front();
        if (out_color !== want.color || out_status !== want.status ||
            out_image_last !== want.image_last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp color=%h st=%b last=%b got color=%h st=%b last=%b",
                     want.color, want.status, want.image_last,
                     out_color, out_status, out_image_last);
        end
      end
    end
  end

  // receiver stalls on its own rhythm, with calm stretches
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  int burst_left = 0;

  // send one transaction, holding valid and payload until accepted
  task automatic send_xact(xact_t x);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= x.kind;
    in_entry_index <= x.idx;
    in_entry_key <= x.key;
    in_entry_color <= x.col;
    in_pixel_value <= x.value;
    in_pixel_last <= x.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_xact(x);
    @(negedge clk);
  endtask

  // idle the sender until every expected pixel has come back, then drain
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (PIXEL_CYCLES + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) cur_mode = val[1:0];
    else if (idx == CFG_BAND_COUNT) cur_bands = val[2:0];
    else cur_entries = val;
    @(negedge clk);
  endtask

  function automatic xact_t load_x(int i, logic signed [31:0] k, logic [31:0] c);
    xact_t x;
    x = '0;
    x.kind = KIND_LOAD;
    x.idx = i[3:0];
    x.key = k;
    x.col = c;
    x.value = $urandom;
    x.last = 1'($urandom_range(0, 1));
    return x;
  endfunction

  function automatic xact_t pix_x(logic signed [31:0] v, logic l);
    xact_t x;
    x = '0;
    x.kind = KIND_PIXEL;
    x.idx = 4'($urandom);
    x.key = $urandom;
    x.col = $urandom;
    x.value = v;
    x.last = l;
    return x;
  endfunction

  // ascending keys, random spacing, random colors; every slot written
  task automatic load_sorted_table(logic signed [31:0] base, int stride);
    logic signed [31:0] k;
    k = base;
    for (int i = 0; i < SLOTS; i++) begin
      send_xact(load_x(i, k, $urandom));
      k = k + 1 + $urandom_range(0, stride);
    end
  endtask

  // directed rows: value plus a typed expectation where it is plain
  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         bands;
    logic signed [31:0] value;
    bit                 typed;
    pixel_res_t         want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    int k;
    xact_t x;
    // table: slot0 key -10 col 0x11223344, slot1 key 10 col 0x55667788,
    // slot2 key 2^31-1 col ffffffff
    dir_rows = '{
      '{MODE_VALUES,    BANDS_FOUR,  -32'sd10, 1, '{32'h11223344, STATUS_OK, 1'b0}},
      '{MODE_VALUES,    BANDS_FOUR,  32'sd5,   1, '{32'h0, STATUS_OK, 1'b1}},
      '{MODE_VALUES,    BANDS_ONE,   32'sd10,  1, '{32'h88, STATUS_OK, 1'b0}},
      '{MODE_VALUES,    BANDS_THREE, 32'sh7fffffff, 1, '{32'h00ffffff, STATUS_OK, 1'b1}},
      '{MODE_INTERVALS, BANDS_FOUR,  32'sh80000000, 1, '{32'h11223344, STATUS_OK, 1'b0}},
      '{MODE_INTERVALS, BANDS_FOUR,  32'sd0,   1, '{32'h11223344, STATUS_OK, 1'b0}},
      '{MODE_INTERVALS, BANDS_FOUR,  32'sd10,  1, '{32'h55667788, STATUS_OK, 1'b0}},
      '{MODE_RAMP,      BANDS_FOUR,  32'sd0,   0, '0},
      '{MODE_RAMP,      BANDS_FOUR,  32'sd9,   0, '0},
      '{MODE_RAMP,      BANDS_FOUR,  32'sd1000, 0, '0},
      '{2'd3,           BANDS_FOUR,  -32'sd3,  0, '0},
      '{MODE_RAMP,      BANDS_THREE, 32'sh7ffffffe, 0, '0},
      '{MODE_RAMP,      3'd0,        32'sd0,   1, '{32'h0, STATUS_BAD_BAND, 1'b1}},
      '{MODE_VALUES,    3'd2,        32'sd10,  1, '{32'h0, STATUS_BAD_BAND, 1'b0}},
      '{MODE_INTERVALS, 3'd5,        32'sd10,  1, '{32'h0, STATUS_BAD_BAND, 1'b1}},
      '{MODE_RAMP,      3'd7,        32'sd10,  1, '{32'h0, STATUS_BAD_BAND, 1'b0}}
    };
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_col[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset config: values mode, three bands, one entry
    send_xact(load_x(0, 32'sd7, 32'hdeadbeef));
    send_xact(pix_x(32'sd7, 1'b1));
    drain_block();

    // directed part, slot index 18 wraps onto slot 2 via the 4-bit port
    write_reg(CFG_ENTRY_COUNT, 5'd3);
    send_xact(load_x(0, -32'sd10, 32'h11223344));
    send_xact(load_x(1, 32'sd10, 32'h55667788));
    send_xact(load_x(18, 32'sh7fffffff, 32'hffffffff));
    foreach (dir_rows[r]) begin
      drain_block();
      write_reg(CFG_MODE, 5'(dir_rows[r].mode));
      write_reg(CFG_BAND_COUNT, 5'(dir_rows[r].bands));
      x = pix_x(dir_rows[r].value, dir_rows[r].want.image_last);
      send_xact(x);
      // typed rows double check the predictor itself
      if (dir_rows[r].typed && pending_colors[$] != dir_rows[r].want) begin
        failed = 1'b1;
        $display("directed row %0d: predictor disagrees with table", r);
      end
    end
    drain_block();
    // entry count 0 taken as 1, 31 saturates; duplicate keys
    write_reg(CFG_BAND_COUNT, 5'(BANDS_FOUR));
    load_sorted_table(-32'sd50, 6);
    send_xact(load_x(3, 32'sd1000, 32'h01020304));
    send_xact(load_x(4, 32'sd1000, 32'h0a0b0c0d));
    drain_block();
    write_reg(CFG_ENTRY_COUNT, 5'd0);
    send_xact(pix_x(-32'sd50, 1'b0));
    send_xact(pix_x(32'sd1000, 1'b1));
    drain_block();
    write_reg(CFG_ENTRY_COUNT, 5'd31);
    send_xact(pix_x(32'sd1000, 1'b0));
    send_xact(pix_x(32'sd900, 1'b0));

    // random phases
    k = 0;
    while (k < 650) begin
      drain_block();
      write_reg(CFG_MODE, 5'($urandom_range(0, 3)));
      write_reg(CFG_BAND_COUNT, 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                : ($urandom_range(0, 1) ? BANDS_FOUR : ($urandom_range(0, 1) ? BANDS_ONE
                : BANDS_THREE))));
      write_reg(CFG_ENTRY_COUNT, 5'($urandom_range(0, 6) == 0 ? $urandom_range(17, 31)
                : $urandom_range(0, 16)));
      case ($urandom_range(0, 3))
        0: load_sorted_table(32'sh80000000, 3);
        1: load_sorted_table($urandom_range(0, 2000) - 1000, 400);
        2: load_sorted_table(32'sh7fffffff - 32'sd200, 2);
        default: begin
          // unsorted noise, every slot still written
          for (int i = 0; i < SLOTS; i++) send_xact(load_x(i, $urandom, $urandom));
        end
      endcase
      for (int j = 0; j < 60; j++) begin
        int lo;
        lo = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 4))
          0: send_xact(pix_x($urandom, 1'($urandom_range(0, 1))));
          1: send_xact(pix_x(shadow_key[lo], 1'($urandom_range(0, 1))));
          2: send_xact(pix_x(shadow_key[lo] + $urandom_range(0, 3) - 1,
                             1'($urandom_range(0, 1))));
          3: send_xact(pix_x(shadow_key[lo] + ((shadow_key[(lo + 1) % SLOTS] - shadow_key[lo])
                             >>> 1), 1'($urandom_range(0, 1))));
          default: send_xact(load_x($urandom, shadow_key[lo], $urandom));
        endcase
        k++;
      end
    end
    drain_block();
    if (!failed && pending_colors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cmli_pkg.sv
hw/rtl/cmli_cell.sv
hw/rtl/cmli_div.sv
hw/rtl/color_map_lookup_interpolate.sv
test/tb_color_map_lookup_interpolate.sv
